// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers, included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, muted while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- hw/rtl/mve_pkg.sv -----
`default_nettype none
package mve_pkg;

   // Block dimensions.
   localparam int MOTORS    = 8;
   localparam int POS_DEPTH = 16;
   localparam int VEL_DEPTH = 16;

   localparam int MOT_W   = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int PSLOT_W = $clog2(POS_DEPTH);
   localparam int VSLOT_W = (VEL_DEPTH > 1) ? $clog2(VEL_DEPTH) : 1;
   localparam int WIN_W   = 5;

   // Field widths.
   localparam int TIME_W = 32;
   localparam int POS_W  = 24;
   localparam int VEL_W  = 32;
   localparam int DIFF_W = POS_W + 1;
   localparam int SUM_W  = VEL_W + VSLOT_W;

   // Divider sizing: |diff| * 1e6 plus half the divisor.
   localparam int SCALE_W    = 20;
   localparam int PROD_W     = DIFF_W + SCALE_W;
   localparam int DIV_NUM_W  = PROD_W + 1;
   localparam int DIV_DEN_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

   localparam logic [SCALE_W-1:0] US_PER_SEC = SCALE_W'(1000000);

   // Configuration port.
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POS_WINDOW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VEL_WINDOW   = 2'd2;

   localparam logic [15:0]      MIN_INTERVAL_RST = 16'd250;
   localparam logic [WIN_W-1:0] POS_WINDOW_RST   = 5'd8;
   localparam logic [WIN_W-1:0] VEL_WINDOW_RST   = 5'd4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             load;
      logic             gate;
      logic             pos_wr;
      logic             mul;
      logic             div_vel;
      logic             vel_wr;
      logic             sum_clr;
      logic             sum_rd;
      logic             sum_acc;
      logic             div_mean;
      logic             mean_wr;
      logic [MOT_W-1:0] motor;
      logic [VSLOT_W-1:0] slot;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic             take;
      logic             pos_full;
      logic             vel_full;
      logic             div_done;
      logic [WIN_W-1:0] vel_win;
   } stat_type;

endpackage
`default_nettype wire

// ----- hw/rtl/mve_if.sv -----
`default_nettype none
// Sample channel: one timestamped word of all motor positions.
interface mve_req_if;
   import mve_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [TIME_W-1:0]       time_us;
   logic signed [POS_W-1:0] pos_0;
   logic signed [POS_W-1:0] pos_1;
   logic signed [POS_W-1:0] pos_2;
   logic signed [POS_W-1:0] pos_3;
   logic signed [POS_W-1:0] pos_4;
   logic signed [POS_W-1:0] pos_5;
   logic signed [POS_W-1:0] pos_6;
   logic signed [POS_W-1:0] pos_7;
   modport source (output valid, time_us, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                   pos_6, pos_7, input ready);
   modport sink (input valid, time_us, pos_0, pos_1, pos_2, pos_3, pos_4, pos_5,
                 pos_6, pos_7, output ready);
endinterface

// Result channel: gate flag, valid flag and the filtered velocities.
interface mve_rsp_if;
   import mve_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    sample_taken;
   logic                    velocity_valid;
   logic signed [VEL_W-1:0] vel_0;
   logic signed [VEL_W-1:0] vel_1;
   logic signed [VEL_W-1:0] vel_2;
   logic signed [VEL_W-1:0] vel_3;
   logic signed [VEL_W-1:0] vel_4;
   logic signed [VEL_W-1:0] vel_5;
   logic signed [VEL_W-1:0] vel_6;
   logic signed [VEL_W-1:0] vel_7;
   modport source (output valid, sample_taken, velocity_valid, vel_0, vel_1, vel_2,
                   vel_3, vel_4, vel_5, vel_6, vel_7, input ready);
   modport sink (input valid, sample_taken, velocity_valid, vel_0, vel_1, vel_2,
                 vel_3, vel_4, vel_5, vel_6, vel_7, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mve_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, unsigned operands.
module mve_div import mve_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic [DIV_NUM_W-1:0]      quo
);

   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W+1:0] trial;
   logic                 fits;

   // Shift in the next dividend bit and try to subtract the divisor.
   assign rem_sh = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, den_ff};
   assign fits   = !trial[DIV_DEN_W+1];

   // Control: count the steps and flag the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands: remainder and quotient share the shift.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? trial[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/mve_dp.sv -----
`default_nettype none
// Datapath: registers, rings, difference, scaling, sums and the divider.
module mve_dp import mve_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DAT_W-1:0]    csr_wdata,
   input  wire logic [TIME_W-1:0]       in_time,
   input  wire logic signed [POS_W-1:0] in_pos [MOTORS],
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   output logic                         taken,
   output logic                         vel_valid,
   output logic signed [VEL_W-1:0]      vel_out [MOTORS]
);

   localparam int PROW = MOTORS * POS_DEPTH;
   localparam int VROW = MOTORS * VEL_DEPTH;

   // Configuration registers.
   logic [15:0]      min_int_ff;
   logic [WIN_W-1:0] pos_win_ff;
   logic [WIN_W-1:0] vel_win_ff;
   logic [WIN_W-1:0] pw;
   logic [WIN_W-1:0] vw;

   // Latched sample.
   logic [TIME_W-1:0]       smp_time_ff;
   logic signed [POS_W-1:0] smp_pos_ff [MOTORS];

   // Ring control state.
   logic [PSLOT_W-1:0] pslot_ff;
   logic [VSLOT_W-1:0] vslot_ff;
   logic [PSLOT_W-1:0] ps_ff;
   logic [PSLOT_W-1:0] old_ff;
   logic [VSLOT_W-1:0] vs_ff;
   logic               pfull_ff;
   logic               vfull_ff;
   logic [TIME_W-1:0]  last_ff;
   logic               seen_ff;
   logic               take_ff;
   logic [POS_DEPTH-1:0] pvalid_ff;
   logic [VEL_DEPTH-1:0] vvalid_ff;
   logic [TIME_W-1:0]  time_ring_ff [POS_DEPTH];
   logic [TIME_W-1:0]  dt_ff;

   // Memories.
   logic signed [POS_W-1:0] pos_mem [PROW];
   logic signed [VEL_W-1:0] vel_mem [VROW];
   logic signed [POS_W-1:0] pos_rd_ff;
   logic                    pos_rdv_ff;
   logic signed [VEL_W-1:0] vel_rd_ff;
   logic                    vel_rdv_ff;

   // Arithmetic registers.
   logic [PROD_W-1:0]       prod_ff;
   logic                    neg_ff;
   logic                    zero_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [VEL_W-1:0] vel_out_ff [MOTORS];

   // Combinational helpers.
   logic                    take;
   logic [TIME_W-1:0]       gap;
   logic [PSLOT_W-1:0]      ps;
   logic [VSLOT_W-1:0]      vs;
   logic                    ps_last;
   logic                    vs_last;
   logic                    pfull_new;
   logic [PSLOT_W-1:0]      old;
   logic [TIME_W-1:0]       old_time;
   logic signed [POS_W-1:0] old_pos;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]       diff_mag;
   logic [SUM_W-1:0]        sum_mag;
   logic [DIV_NUM_W-1:0]    div_num;
   logic [DIV_DEN_W-1:0]    div_den;
   logic                    div_done;
   logic [DIV_NUM_W-1:0]    quo;
   logic signed [VEL_W-1:0] sat_res;

   // Clamp the windows to their legal ranges.
   always_comb begin
      pw = pos_win_ff;
      if (pw < WIN_W'(2)) pw = WIN_W'(2);
      if (pw > WIN_W'(POS_DEPTH)) pw = WIN_W'(POS_DEPTH);
      vw = vel_win_ff;
      if (vw < WIN_W'(1)) vw = WIN_W'(1);
      if (vw > WIN_W'(VEL_DEPTH)) vw = WIN_W'(VEL_DEPTH);
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_int_ff <= MIN_INTERVAL_RST;
         pos_win_ff <= POS_WINDOW_RST;
         vel_win_ff <= VEL_WINDOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_INTERVAL: min_int_ff <= csr_wdata;
            CSR_POS_WINDOW:   pos_win_ff <= csr_wdata[WIN_W-1:0];
            CSR_VEL_WINDOW:   vel_win_ff <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Interval gate and slot arithmetic for the latched sample.
   always_comb begin
      gap       = smp_time_ff - last_ff;
      take      = !seen_ff || (gap >= TIME_W'(min_int_ff));
      ps        = ({1'b0, pslot_ff} >= pw) ? '0 : pslot_ff;
      vs        = ({1'b0, vslot_ff} >= vw) ? '0 : vslot_ff;
      ps_last   = ({1'b0, ps} == pw - 1'b1);
      vs_last   = ({1'b0, vs} == vw - 1'b1);
      pfull_new = pfull_ff || ps_last;
      old       = ps_last ? '0 : ps + 1'b1;
      old_time  = pvalid_ff[old] ? time_ring_ff[old] : '0;
   end

   // Sample latch.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         smp_time_ff <= in_time;
         smp_pos_ff  <= in_pos;
      end
   end

   // Ring bookkeeping, committed once per taken sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         pslot_ff  <= '0;
         vslot_ff  <= '0;
         pfull_ff  <= 1'b0;
         vfull_ff  <= 1'b0;
         last_ff   <= '0;
         seen_ff   <= 1'b0;
         take_ff   <= 1'b0;
         pvalid_ff <= '0;
         vvalid_ff <= '0;
      end else if (cmd.gate) begin
         take_ff <= take;
         if (take) begin
            seen_ff       <= 1'b1;
            last_ff       <= smp_time_ff;
            pvalid_ff[ps] <= 1'b1;
            pfull_ff      <= pfull_new;
            pslot_ff      <= old;
            if (pfull_new) begin
               vvalid_ff[vs] <= 1'b1;
               if (vs_last) vfull_ff <= 1'b1;
               vslot_ff <= vs_last ? '0 : vs + 1'b1;
            end
         end
      end
   end

   // Time ring and the span of this window.
   always_ff @(posedge clock) begin
      if (cmd.gate && take) begin
         time_ring_ff[ps] <= smp_time_ff;
         dt_ff            <= smp_time_ff - old_time;
         ps_ff            <= ps;
         old_ff           <= old;
         vs_ff            <= vs;
      end
   end

   // Position memory: store the new word, fetch the oldest one.
   always_ff @(posedge clock) begin
      if (cmd.pos_wr) begin
         pos_mem[{cmd.motor, ps_ff}] <= smp_pos_ff[cmd.motor];
         pos_rd_ff <= pos_mem[{cmd.motor, old_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pos_wr) pos_rdv_ff <= pvalid_ff[old_ff];
   end

   // Difference and scaling to microseconds per second.
   assign old_pos  = pos_rdv_ff ? pos_rd_ff : '0;
   assign diff     = DIFF_W'(smp_pos_ff[cmd.motor]) - DIFF_W'(old_pos);
   assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= PROD_W'(diff_mag) * PROD_W'(US_PER_SEC);
         neg_ff  <= diff[DIFF_W-1];
         zero_ff <= (diff == '0);
      end else if (cmd.div_mean) begin
         neg_ff  <= sum_ff[SUM_W-1];
         zero_ff <= 1'b0;
      end
   end

   // Divider operands, rounded by adding half the divisor.
   always_comb begin
      if (cmd.div_mean) begin
         div_num = DIV_NUM_W'(sum_mag) + DIV_NUM_W'(vw >> 1);
         div_den = DIV_DEN_W'(vw);
      end else begin
         div_num = {1'b0, prod_ff} + DIV_NUM_W'(dt_ff >> 1);
         div_den = dt_ff;
      end
   end

   mve_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_vel || cmd.div_mean),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   // Sign and saturation of the quotient.
   always_comb begin
      if (zero_ff) begin
         sat_res = '0;
      end else if (neg_ff) begin
         if ((|quo[DIV_NUM_W-1:VEL_W]) || (quo[VEL_W-1] && (|quo[VEL_W-2:0])))
            sat_res = {1'b1, {(VEL_W-1){1'b0}}};
         else
            sat_res = -$signed(quo[VEL_W-1:0]);
      end else begin
         if (|quo[DIV_NUM_W-1:VEL_W-1])
            sat_res = {1'b0, {(VEL_W-1){1'b1}}};
         else
            sat_res = $signed(quo[VEL_W-1:0]);
      end
   end

   // Velocity memory: raw velocity writes and mean-pass reads.
   always_ff @(posedge clock) begin
      if (cmd.vel_wr) vel_mem[{cmd.motor, vs_ff}] <= sat_res;
      if (cmd.sum_rd) vel_rd_ff <= vel_mem[{cmd.motor, cmd.slot}];
   end

   always_ff @(posedge clock) begin
      if (cmd.sum_rd) vel_rdv_ff <= vvalid_ff[cmd.slot];
   end

   // Running sum over the velocity window.
   always_ff @(posedge clock) begin
      if (cmd.sum_clr)
         sum_ff <= '0;
      else if (cmd.sum_acc && vel_rdv_ff)
         sum_ff <= sum_ff + SUM_W'(vel_rd_ff);
   end

   // Result registers, cleared for each new word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int m = 0; m < MOTORS; m++) vel_out_ff[m] <= '0;
      end else if (cmd.mean_wr) begin
         vel_out_ff[cmd.motor] <= sat_res;
      end
   end

   assign stat.take     = take;
   assign stat.pos_full = pfull_ff;
   assign stat.vel_full = vfull_ff;
   assign stat.div_done = div_done;
   assign stat.vel_win  = vw;

   assign taken     = take_ff;
   assign vel_valid = vfull_ff;
   assign vel_out   = vel_out_ff;

endmodule
`default_nettype wire

// ----- hw/rtl/mve_ctrl.sv -----
`default_nettype none
// Controller: sequences gate, per-motor difference and per-motor mean.
module mve_ctrl import mve_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_GATE   = 4'd1;
   localparam logic [3:0] S_PWR    = 4'd2;
   localparam logic [3:0] S_MUL    = 4'd3;
   localparam logic [3:0] S_DVEL   = 4'd4;
   localparam logic [3:0] S_WVEL   = 4'd5;
   localparam logic [3:0] S_VWR    = 4'd6;
   localparam logic [3:0] S_MCHK   = 4'd7;
   localparam logic [3:0] S_SRD    = 4'd8;
   localparam logic [3:0] S_SACC   = 4'd9;
   localparam logic [3:0] S_DMEAN  = 4'd10;
   localparam logic [3:0] S_WMEAN  = 4'd11;
   localparam logic [3:0] S_MWR    = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   localparam logic [MOT_W-1:0] LAST_MOTOR = MOT_W'(MOTORS - 1);

   logic [3:0]         state_ff;
   logic [3:0]         state_in;
   logic [MOT_W-1:0]   motor_ff;
   logic [MOT_W-1:0]   motor_in;
   logic [VSLOT_W-1:0] slot_ff;
   logic [VSLOT_W-1:0] slot_in;
   logic               last_slot;

   assign last_slot = ({1'b0, slot_ff} == stat.vel_win - 1'b1);

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      motor_in  = motor_ff;
      slot_in   = slot_ff;
      cmd       = '0;
      cmd.motor = motor_ff;
      cmd.slot  = slot_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_GATE;
            end
         end
         S_GATE: begin
            cmd.gate = 1'b1;
            motor_in = '0;
            state_in = stat.take ? S_PWR : S_MCHK;
         end
         S_PWR: begin
            cmd.pos_wr = 1'b1;
            if (stat.pos_full) begin
               state_in = S_MUL;
            end else if (motor_ff == LAST_MOTOR) begin
               state_in = S_MCHK;
            end else begin
               motor_in = motor_ff + 1'b1;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DVEL;
         end
         S_DVEL: begin
            cmd.div_vel = 1'b1;
            state_in    = S_WVEL;
         end
         S_WVEL: begin
            if (stat.div_done) state_in = S_VWR;
         end
         S_VWR: begin
            cmd.vel_wr = 1'b1;
            if (motor_ff == LAST_MOTOR) begin
               state_in = S_MCHK;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = S_PWR;
            end
         end
         S_MCHK: begin
            motor_in    = '0;
            slot_in     = '0;
            cmd.sum_clr = 1'b1;
            state_in    = stat.vel_full ? S_SRD : S_OUT;
         end
         S_SRD: begin
            cmd.sum_rd = 1'b1;
            state_in   = S_SACC;
         end
         S_SACC: begin
            cmd.sum_acc = 1'b1;
            if (last_slot) begin
               slot_in  = '0;
               state_in = S_DMEAN;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         S_DMEAN: begin
            cmd.div_mean = 1'b1;
            state_in     = S_WMEAN;
         end
         S_WMEAN: begin
            if (stat.div_done) state_in = S_MWR;
         end
         S_MWR: begin
            cmd.mean_wr = 1'b1;
            cmd.sum_clr = 1'b1;
            if (motor_ff == LAST_MOTOR) begin
               state_in = S_OUT;
            end else begin
               motor_in = motor_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         motor_ff <= '0;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
         slot_ff  <= slot_in;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/motor_velocity_estimator_core.sv -----
`default_nettype none
// Motor velocity estimator. Each sample word carries a microsecond time stamp and
// eight positions; a word closer than min_interval_us to the last taken one is
// skipped. Taken words fill a position ring; once it is full each motor's raw
// velocity (newest minus oldest position, times 1e6, over the time span, rounded
// and saturated) goes into a velocity ring, and once that is full every result
// word carries the rounded mean of the ring per motor. One word is handled at a
// time and one result word follows each sample word. The 46-step serial divider
// is shared by both passes. The rings read as zero until written.
module motor_velocity_estimator_core import mve_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   mve_req_if.sink                   req_ch,
   mve_rsp_if.source                 rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

`include "assert_macros.svh"

   cmd_type                 cmd;
   stat_type                stat;
   logic signed [POS_W-1:0] in_pos [MOTORS];
   logic signed [VEL_W-1:0] vel_out [MOTORS];
   logic                    taken;
   logic                    vel_valid;

   assign in_pos[0] = req_ch.pos_0;
   assign in_pos[1] = req_ch.pos_1;
   assign in_pos[2] = req_ch.pos_2;
   assign in_pos[3] = req_ch.pos_3;
   assign in_pos[4] = req_ch.pos_4;
   assign in_pos[5] = req_ch.pos_5;
   assign in_pos[6] = req_ch.pos_6;
   assign in_pos[7] = req_ch.pos_7;

   mve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mve_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_time   (req_ch.time_us),
      .in_pos    (in_pos),
      .cmd       (cmd),
      .stat      (stat),
      .taken     (taken),
      .vel_valid (vel_valid),
      .vel_out   (vel_out)
   );

   assign rsp_ch.sample_taken   = taken;
   assign rsp_ch.velocity_valid = vel_valid;
   assign rsp_ch.vel_0 = vel_out[0];
   assign rsp_ch.vel_1 = vel_out[1];
   assign rsp_ch.vel_2 = vel_out[2];
   assign rsp_ch.vel_3 = vel_out[3];
   assign rsp_ch.vel_4 = vel_out[4];
   assign rsp_ch.vel_5 = vel_out[5];
   assign rsp_ch.vel_6 = vel_out[6];
   assign rsp_ch.vel_7 = vel_out[7];

   // A result and a new sample never overlap.
   `ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_ch.valid, !req_ch.ready)
   // An accepted word is gated in the following cycle.
   `ASSERT_NEXT(a_gate_follows, clock, reset, req_ch.valid && req_ch.ready, cmd.gate)
   // Velocities stay zero until the velocity ring is full.
   `ASSERT_IMPLY(a_zero_invalid, clock, reset, rsp_ch.valid && !rsp_ch.velocity_valid,
                 rsp_ch.vel_0 == '0 && rsp_ch.vel_7 == '0)
   // The divider is never restarted while a mean pass is reading.
   `ASSERT_IMPLY(a_one_cmd, clock, reset, cmd.sum_rd, !cmd.div_mean && !cmd.div_vel)

endmodule
`default_nettype wire
